// ----- rtl/lpc_pkg.sv -----
// Shared types and constants for the line position centroid block.
// Used by the interfaces, the divider and the top level; depends on nothing.
package lpc_pkg;

   localparam int NUM_SENSORS = 5;
   localparam int SAMPLE_W    = 12;
   localparam int ADC_BITS    = 12;

   // Conditioned sample and accumulator widths follow from the ADC resolution
   localparam int V_W    = ADC_BITS;
   localparam int CMP_W  = (V_W > SAMPLE_W) ? V_W : SAMPLE_W;
   localparam int SUM_W  = V_W + 3;
   localparam int WSUM_W = V_W + 11;
   localparam int DEN_W  = V_W + 10;

   localparam int WEIGHT_W = 8;
   localparam int MUL_A_W  = WEIGHT_W + 1;
   localparam int MUL_B_W  = SUM_W + 1;
   localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

   localparam int IDX_W      = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = WEIGHT_W;

   localparam int Q_FRAC    = 14;
   localparam int QUOT_W    = Q_FRAC + 1;
   localparam int DIV_CNT_W = 4;
   localparam int ERR_W     = 16;

   localparam logic [CMP_W-1:0] FULL_SCALE = CMP_W'((64'd1 << V_W) - 64'd1);

   localparam logic signed [ERR_W-1:0] Q_ONE       = ERR_W'(16384);
   localparam logic signed [ERR_W-1:0] Q_MINUS_ONE = -Q_ONE;

   localparam logic [CSR_IDX_W-1:0] CSR_DARK_MODE = CSR_IDX_W'(NUM_SENSORS);

   localparam logic signed [WEIGHT_W-1:0] WEIGHT_RESET [NUM_SENSORS] =
      '{-8'sd2, -8'sd1, 8'sd0, 8'sd1, 8'sd2};

   typedef struct packed {
      logic             start;
      logic [DEN_W-1:0] num;
      logic [DEN_W-1:0] den;
   } lpc_div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } lpc_div_rsp_type;

endpackage

// ----- rtl/lpc_if.sv -----
// Valid/ready channel interfaces for sensor requests and steering results.
// Depends on lpc_pkg for the field widths.
interface lpc_req_if import lpc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_0;
   logic [SAMPLE_W-1:0] sample_1;
   logic [SAMPLE_W-1:0] sample_2;
   logic [SAMPLE_W-1:0] sample_3;
   logic [SAMPLE_W-1:0] sample_4;

   modport source (output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                   input ready);
   modport sink   (input valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                   output ready);
endinterface

interface lpc_rsp_if import lpc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [ERR_W-1:0] steer_error;
   logic                    line_seen;

   modport source (output valid, steer_error, line_seen, input ready);
   modport sink   (input valid, steer_error, line_seen, output ready);
endinterface

// ----- rtl/lpc_div.sv -----
// Restoring divider, one quotient bit per cycle, for the Q1.14 centroid ratio.
// Depends on lpc_pkg. The dividend magnitude never exceeds the divisor.
module lpc_div import lpc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  lpc_div_cmd_type cmd,
   output lpc_div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [QUOT_W-1:0]    quot_ff, quot_in;

   logic [DEN_W:0] cand;
   logic [DEN_W:0] diff;
   logic           ge;

   // First step tests the integer bit; later steps shift the remainder up
   assign cand = (cnt_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign ge   = cand >= {1'b0, den_ff};
   assign diff = cand - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = cmd.num;
         den_in  = cmd.den;
         quot_in = '0;
      end else if (busy_ff) begin
         quot_in = {quot_ff[QUOT_W-2:0], ge};
         rem_in  = ge ? diff[DEN_W-1:0] : cand[DEN_W-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(QUOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      busy_ff && cnt_ff != '0 |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("divider started while busy");

endmodule

// ----- rtl/line_position_centroid.sv -----
// Line position centroid: top level with sequencer, shared multiplier and
// configuration registers. Depends on lpc_pkg, lpc_if and lpc_div.
//
// Usage:
//   req_bus carries one request of five ADC samples, taken when valid and
//   ready are high together. ready is high only while the sequencer is idle.
//   rsp_bus returns one result per request: steer_error (Q1.14) and
//   line_seen. The result sits in an output register, so the next request
//   is taken while a finished result still waits for rsp_bus.ready.
//   csr_wr_en writes csr_wdata into register csr_index: 0..4 are the signed
//   sensor weights, 5 the dark-line mode bit; other indices are ignored.
//   Write registers only while no request is in flight.
// Operation:
//   One shared 9x16 multiplier does the five multiply-accumulate steps, then
//   forms the divisor sum*maxw; a restoring divider then forms the quotient
//   one bit at a time. A lost line skips the divider. The sequencer returns
//   to idle only once the result is loaded into the output register, so a
//   new request is never taken while the last one is still in progress.
// Reset clears the sequencer, the output valid flag, the weights to -2..2,
// dark-line mode to 1 and the remembered error sign to nonnegative. A stalled
// receiver holds the result; the block finishes at most one more request and
// then waits in its output state.
module line_position_centroid import lpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lpc_req_if.sink               req_bus,
   lpc_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAC,
      S_DEN,
      S_DIV,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic signed [WEIGHT_W-1:0] weight_ff [NUM_SENSORS];
   logic                       dark_ff;
   logic                       last_nonneg_ff, last_nonneg_in;

   logic [V_W-1:0]             v_ff [NUM_SENSORS];
   logic [V_W-1:0]             v_in [NUM_SENSORS];
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic signed [WSUM_W-1:0]   wsum_ff, wsum_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [WEIGHT_W-1:0]        maxw_ff, maxw_in;
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic                       seen_ff, seen_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [ERR_W-1:0]    rsp_err_ff, rsp_err_in;
   logic                       rsp_seen_ff, rsp_seen_in;

   logic                       accept;
   logic                       out_free;
   logic                       line_found;
   logic signed [WEIGHT_W-1:0] cur_w;
   logic [WEIGHT_W-1:0]        cur_aw;
   logic [WEIGHT_W-1:0]        maxw_eff;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [MUL_P_W-1:0]  product;
   logic signed [WSUM_W-1:0]   wsum_abs;
   lpc_div_cmd_type            div_cmd;
   lpc_div_rsp_type            div_rsp;

   // Saturate to full scale, then invert for a dark line
   function automatic logic [V_W-1:0] condition(input logic [SAMPLE_W-1:0] sample,
                                                input logic dark);
      logic [CMP_W-1:0] s;
      s = CMP_W'(sample);
      if (s > FULL_SCALE) s = FULL_SCALE;
      if (dark) s = FULL_SCALE - s;
      return s[V_W-1:0];
   endfunction

   assign accept   = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready       = (state_ff == S_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.steer_error = rsp_err_ff;
   assign rsp_bus.line_seen   = rsp_seen_ff;

   assign v_in[0] = condition(req_bus.sample_0, dark_ff);
   assign v_in[1] = condition(req_bus.sample_1, dark_ff);
   assign v_in[2] = condition(req_bus.sample_2, dark_ff);
   assign v_in[3] = condition(req_bus.sample_3, dark_ff);
   assign v_in[4] = condition(req_bus.sample_4, dark_ff);

   assign cur_w    = weight_ff[idx_ff];
   assign cur_aw   = cur_w[WEIGHT_W-1] ? WEIGHT_W'(~cur_w + 1'b1) : WEIGHT_W'(cur_w);
   assign maxw_eff = (maxw_ff == '0) ? WEIGHT_W'(1) : maxw_ff;

   // Shared multiplier: weight * sample while accumulating, maxw * sum after
   always_comb begin
      if (state_ff == S_MAC) begin
         mul_a = MUL_A_W'(cur_w);
         mul_b = $signed({{(MUL_B_W-V_W){1'b0}}, v_ff[idx_ff]});
      end else begin
         mul_a = $signed({1'b0, maxw_eff});
         mul_b = $signed({1'b0, sum_ff});
      end
   end
   assign product = mul_a * mul_b;

   assign line_found = sum_ff >= SUM_W'(2);
   assign wsum_abs   = wsum_ff[WSUM_W-1] ? -wsum_ff : wsum_ff;

   assign div_cmd.start = (state_ff == S_DEN) && line_found;
   assign div_cmd.num   = wsum_abs[DEN_W-1:0];
   assign div_cmd.den   = product[DEN_W-1:0];

   lpc_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      wsum_in        = wsum_ff;
      sum_in         = sum_ff;
      maxw_in        = maxw_ff;
      err_in         = err_ff;
      seen_in        = seen_ff;
      last_nonneg_in = last_nonneg_ff;
      rsp_err_in     = rsp_err_ff;
      rsp_seen_in    = rsp_seen_ff;
      rsp_valid_in   = rsp_bus.ready ? 1'b0 : rsp_valid_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in   = '0;
               wsum_in  = '0;
               sum_in   = '0;
               maxw_in  = '0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            wsum_in = wsum_ff + product[WSUM_W-1:0];
            sum_in  = sum_ff + SUM_W'(v_ff[idx_ff]);
            if (cur_aw > maxw_ff) maxw_in = cur_aw;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(NUM_SENSORS - 1)) state_in = S_DEN;
         end
         S_DEN: begin
            if (line_found) begin
               state_in = S_DIV;
            end else begin
               // line lost: steer hard towards the last seen side
               err_in   = last_nonneg_ff ? Q_ONE : Q_MINUS_ONE;
               seen_in  = 1'b0;
               state_in = S_OUT;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               err_in   = wsum_ff[WSUM_W-1] ? -$signed({1'b0, div_rsp.quot})
                                            : $signed({1'b0, div_rsp.quot});
               seen_in  = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = err_ff;
               rsp_seen_in  = seen_ff;
               if (seen_ff) last_nonneg_in = !err_ff[ERR_W-1];
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         last_nonneg_ff <= 1'b1;
         dark_ff        <= 1'b1;
         for (int i = 0; i < NUM_SENSORS; i++) weight_ff[i] <= WEIGHT_RESET[i];
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         last_nonneg_ff <= last_nonneg_in;
         if (csr_wr_en) begin
            if (csr_index < CSR_DARK_MODE) weight_ff[csr_index] <= $signed(csr_wdata);
            else if (csr_index == CSR_DARK_MODE) dark_ff <= csr_wdata[0];
         end
      end
      if (accept) begin
         for (int i = 0; i < NUM_SENSORS; i++) v_ff[i] <= v_in[i];
      end
      idx_ff      <= idx_in;
      wsum_ff     <= wsum_in;
      sum_ff      <= sum_in;
      maxw_ff     <= maxw_in;
      err_ff      <= err_in;
      seen_ff     <= seen_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_seen_ff <= rsp_seen_in;
   end

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide phase");

   a_lost_full_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_seen_ff |-> rsp_err_ff == Q_ONE || rsp_err_ff == Q_MINUS_ONE)
      else $error("lost-line result is not full scale");

   a_seen_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_seen_ff |-> rsp_err_ff <= Q_ONE && rsp_err_ff >= Q_MINUS_ONE)
      else $error("steering error outside Q1.14 range");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_MAC && idx_ff == '0 && sum_ff == '0)
      else $error("request did not start accumulation");

endmodule
